// File: rtl/top_k_sorted_insert_core_defines.svh
// Assertion macros shared by the top-k insertion list RTL.
// No dependencies; expects clk and arst_n in the including scope.
`ifndef TOP_K_SORTED_INSERT_CORE_DEFINES_SVH
`define TOP_K_SORTED_INSERT_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TKINS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define TKINS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/tkins_pkg.sv
// Shared types and constants for the top-k insertion list.
// No dependencies.
package tkins_pkg;

	localparam int ENTRIES_DEF = 8;
	localparam int SCORE_W     = 32;
	localparam int TAG_W       = 64;
	localparam int INDEX_W     = 3;
	localparam int POS_W       = 3;
	localparam int COUNT_W     = 4;
	localparam int IN_DATA_W   = 104;
	localparam int OUT_DATA_W  = 112;

	typedef enum logic {
		ACT_SUBMIT = 1'b0,
		ACT_READ   = 1'b1
	} action_t;

	// per-cell update control
	typedef struct packed {
		logic load_new;  // take the submitted pair
		logic shift_in;  // take the upper neighbor's pair
	} cell_ctl_t;

endpackage

// File: rtl/tkins_cell.sv
// One rank of the sorted list: holds a score/tag pair and compares it.
// Depends on tkins_pkg.
module tkins_cell import tkins_pkg::*; (
	input  logic                      clk,
	input  cell_ctl_t                 ctl,
	input  logic signed [SCORE_W-1:0] new_score,
	input  logic        [TAG_W-1:0]   new_tag,
	input  logic signed [SCORE_W-1:0] prev_score,
	input  logic        [TAG_W-1:0]   prev_tag,
	output logic signed [SCORE_W-1:0] score,
	output logic        [TAG_W-1:0]   tag,
	output logic                      beats    // new score strictly above ours
);

	logic signed [SCORE_W-1:0] score_q;
	logic        [TAG_W-1:0]   tag_q;

	always_ff @(posedge clk) begin
		if (ctl.load_new) begin
			score_q <= new_score;
			tag_q   <= new_tag;
		end else if (ctl.shift_in) begin
			score_q <= prev_score;
			tag_q   <= prev_tag;
		end
	end

	assign score = score_q;
	assign tag   = tag_q;
	assign beats = new_score > score_q;

endmodule

// File: rtl/top_k_sorted_insert_core.sv
// Top-k sorted insertion list: a row of compare-and-shift cells.
// Throughput: one item per cycle unless m_tready stalls; results are registered.
// The rate is set by the combinational parallel compare across all cells and the shift.
// Reset (arst_n low, async) empties the list and drops any pending result.
// Cell contents have no reset; only ranks below the entry count are ever read.
// Depends on tkins_pkg, tkins_cell and top_k_sorted_insert_core_defines.svh.
`include "top_k_sorted_insert_core_defines.svh"

module top_k_sorted_insert_core import tkins_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // score[31:0], tag[95:32], index[98:96], zero pad
	input  logic                  s_tuser,   // action: 0 submit, 1 read
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata    // accepted[0], position[3:1], entry_count[7:4],
	                                         // read_valid[8], read_score[40:9],
	                                         // read_tag[104:41], zero pad
);

	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int RD_N  = (ENTRIES < 8) ? ENTRIES : 8;  // ranks reachable by a 3-bit index

	// input field unpack
	logic signed [SCORE_W-1:0] in_score;
	logic        [TAG_W-1:0]   in_tag;
	logic        [INDEX_W-1:0] in_index;
	action_t                   in_action;

	assign in_score  = s_tdata[SCORE_W-1:0];
	assign in_tag    = s_tdata[SCORE_W+TAG_W-1:SCORE_W];
	assign in_index  = s_tdata[SCORE_W+TAG_W+INDEX_W-1:SCORE_W+TAG_W];
	assign in_action = action_t'(s_tuser);

	// transfer handling: output register parts the two sides
	logic out_valid_q;
	logic in_xfer;
	logic submit_go;

	assign s_tready  = !out_valid_q || m_tready;
	assign in_xfer   = s_tvalid && s_tready;
	assign submit_go = in_xfer && (in_action == ACT_SUBMIT);

	logic [CNT_W-1:0] cnt_q;

	// cell row
	logic signed [SCORE_W-1:0] cell_score [ENTRIES];
	logic        [TAG_W-1:0]   cell_tag   [ENTRIES];
	logic        [ENTRIES-1:0] beats;
	logic        [ENTRIES-1:0] ins;       // new pair belongs at or above this rank
	logic        [ENTRIES-1:0] take_vec;  // one-hot insert rank
	cell_ctl_t                 ctl [ENTRIES];

	// ins is monotone: once true it stays true further down the row
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			ins[i] = (CNT_W'(i) >= cnt_q) || beats[i];
		end
	end

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (i == 0) begin
				take_vec[i]     = submit_go && ins[i];
				ctl[i].shift_in = 1'b0;
			end else begin
				take_vec[i]     = submit_go && ins[i] && !ins[i-1];
				ctl[i].shift_in = submit_go && ins[i-1];
			end
			ctl[i].load_new = take_vec[i];
		end
	end

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		if (g == 0) begin : g_head
			tkins_cell u_cell (
				.clk        (clk),
				.ctl        (ctl[g]),
				.new_score  (in_score),
				.new_tag    (in_tag),
				.prev_score (in_score),
				.prev_tag   (in_tag),
				.score      (cell_score[g]),
				.tag        (cell_tag[g]),
				.beats      (beats[g])
			);
		end else begin : g_body
			tkins_cell u_cell (
				.clk        (clk),
				.ctl        (ctl[g]),
				.new_score  (in_score),
				.new_tag    (in_tag),
				.prev_score (cell_score[g-1]),
				.prev_tag   (cell_tag[g-1]),
				.score      (cell_score[g]),
				.tag        (cell_tag[g]),
				.beats      (beats[g])
			);
		end
	end

	// insert rank from the one-hot vector, kept to the field width
	logic             accept_new;
	logic [POS_W-1:0] ins_pos;

	always_comb begin
		ins_pos = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (take_vec[i]) begin
				ins_pos = ins_pos | POS_W'(i);
			end
		end
	end

	assign accept_new = |take_vec;

	// entry count
	logic [CNT_W-1:0] cnt_next;

	always_comb begin
		cnt_next = cnt_q;
		if (accept_new && (cnt_q < CNT_W'(ENTRIES))) begin
			cnt_next = cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_next;
		end
	end

	// read port: small mux over the reachable ranks, before this item's update
	logic                      rd_hit;
	logic signed [SCORE_W-1:0] rd_score;
	logic        [TAG_W-1:0]   rd_tag;

	always_comb begin
		rd_hit   = 1'b0;
		rd_score = '0;
		rd_tag   = '0;
		for (int j = 0; j < RD_N; j++) begin
			if ((in_index == INDEX_W'(j)) && (CNT_W'(j) < cnt_q)) begin
				rd_hit   = 1'b1;
				rd_score = cell_score[j];
				rd_tag   = cell_tag[j];
			end
		end
	end

	// result register
	logic                      acc_q;
	logic [POS_W-1:0]          pos_q;
	logic [COUNT_W-1:0]        count_q;
	logic                      rvalid_q;
	logic signed [SCORE_W-1:0] rscore_q;
	logic [TAG_W-1:0]          rtag_q;
	logic [COUNT_W-1:0]        count_out;

	if (CNT_W >= COUNT_W) begin : g_cnt_trunc
		assign count_out = cnt_next[COUNT_W-1:0];
	end else begin : g_cnt_ext
		assign count_out = {{(COUNT_W-CNT_W){1'b0}}, cnt_next};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			count_q <= count_out;
			if (in_action == ACT_SUBMIT) begin
				acc_q    <= accept_new;
				pos_q    <= ins_pos;
				rvalid_q <= 1'b0;
				rscore_q <= '0;
				rtag_q   <= '0;
			end else begin
				acc_q    <= 1'b0;
				pos_q    <= '0;
				rvalid_q <= rd_hit;
				rscore_q <= rd_score;
				rtag_q   <= rd_tag;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, rtag_q, rscore_q, rvalid_q, count_q, pos_q, acc_q};

	// checks
	`TKINS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(ENTRIES), "entry count above list size")
	`TKINS_ASSERT_NOW(a_take_onehot, 1'b1, $onehot0(take_vec), "more than one insert rank")
	`TKINS_ASSERT_NEXT(a_cnt_grow, submit_go && (cnt_q < CNT_W'(ENTRIES)), cnt_q == $past(cnt_q) + CNT_W'(1), "submit into non-full list did not grow count")
	`TKINS_ASSERT_NEXT(a_cnt_idle, !submit_go, $stable(cnt_q), "count changed without a submit")

endmodule

// File: verif/tkins_result_checker.sv
// Result checker for the top-k insertion list: predicts every result from the input stream.
// Holds a copy of the ranked list and compares each result transfer field by field.
// Depends on tkins_pkg.
module tkins_result_checker import tkins_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	output int                    fail_count,
	output int                    pending,
	output int                    refused_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                       accepted;
		logic [POS_W-1:0]           position;
		logic [COUNT_W-1:0]         entry_count;
		logic                       read_valid;
		logic signed [SCORE_W-1:0]  read_score;
		logic [TAG_W-1:0]           read_tag;
	} rank_result_t;

	// shadow copy of the ranked list
	logic signed [SCORE_W-1:0] held_scores [ENTRIES];
	logic [TAG_W-1:0]          held_tags   [ENTRIES];
	int                        held_count;

	rank_result_t expected_results [$];

	initial begin
		fail_count    = 0;
		pending       = 0;
		refused_count = 0;
		held_count    = 0;
	end

	task automatic report_error(input string msg);
		$display("[%0t] ERROR: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [TAG_W-1:0] exp_v,
			input logic [TAG_W-1:0] got_v);
		if (exp_v !== got_v)
			report_error($sformatf("%s expected %0h got %0h", name, exp_v, got_v));
	endtask

	// apply one item to the shadow list and form its result
	task automatic predict_rank_step(input action_t act, input logic signed [SCORE_W-1:0] score,
			input logic [TAG_W-1:0] tag, input logic [INDEX_W-1:0] idx,
			output rank_result_t res);
		int slot;
		bit found;
		res   = '0;
		slot  = held_count;
		found = 1'b0;
		if (act == ACT_SUBMIT) begin
			// first entry strictly below the new score; ties rank behind older entries
			for (int i = 0; i < held_count; i++)
				if (!found && score > held_scores[i]) begin
					slot  = i;
					found = 1'b1;
				end
			if (found || held_count < ENTRIES) begin
				for (int i = ENTRIES - 1; i > slot; i--) begin
					held_scores[i] = held_scores[i-1];
					held_tags[i]   = held_tags[i-1];
				end
				held_scores[slot] = score;
				held_tags[slot]   = tag;
				if (held_count < ENTRIES)
					held_count++;
				res.accepted = 1'b1;
				res.position = slot[POS_W-1:0];
			end else begin
				refused_count++;
			end
		end else if (idx < held_count) begin
			res.read_valid = 1'b1;
			res.read_score = held_scores[idx];
			res.read_tag   = held_tags[idx];
		end
		res.entry_count = held_count[COUNT_W-1:0];
	endtask

	always @(posedge clk) begin : monitor
		rank_result_t got_r;
		rank_result_t exp_r;
		rank_result_t pred_r;
		if (!arst_n) begin
			held_count = 0;
			expected_results.delete();
		end else begin
			// result side first: its expectation was queued at an earlier edge
			if (m_tvalid && m_tready) begin
				got_r.accepted    = m_tdata[0];
				got_r.position    = m_tdata[3:1];
				got_r.entry_count = m_tdata[7:4];
				got_r.read_valid  = m_tdata[8];
				got_r.read_score  = m_tdata[40:9];
				got_r.read_tag    = m_tdata[104:41];
				if (expected_results.size() == 0) begin
					report_error($sformatf("result with none expected, tdata %0h", m_tdata));
				end else begin
					exp_r = expected_results.pop_front();
					check_field("accepted", exp_r.accepted, got_r.accepted);
					check_field("position", exp_r.position, got_r.position);
					check_field("entry_count", exp_r.entry_count, got_r.entry_count);
					check_field("read_valid", exp_r.read_valid, got_r.read_valid);
					check_field("read_score", exp_r.read_score, got_r.read_score);
					check_field("read_tag", exp_r.read_tag, got_r.read_tag);
				end
			end
			if (s_tvalid && s_tready) begin
				predict_rank_step(action_t'(s_tuser), s_tdata[31:0], s_tdata[95:32],
					s_tdata[98:96], pred_r);
				expected_results.push_back(pred_r);
			end
		end
		pending = expected_results.size();
	end

endmodule

// File: verif/tb_top_k_sorted_insert_core.sv
// Top of the top-k insertion list testbench: clock, reset, stimulus and verdict.
// Depends on tkins_pkg, top_k_sorted_insert_core and tkins_result_checker.
module tb_top_k_sorted_insert_core import tkins_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	// cycles with no transfer on either side before the run is declared hung
	localparam int HANG_LIMIT = 2000;
	localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7fff_ffff;
	localparam logic signed [SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;
	localparam logic [TAG_W-1:0]          TAG_ONES  = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;   // score[31:0], tag[95:32], index[98:96], zero pad
	logic                  s_tuser = 1'b0; // action: 0 submit, 1 read
	logic                  m_tvalid;
	logic                  m_tready = 1'b1;
	logic [OUT_DATA_W-1:0] m_tdata;        // accepted[0], position[3:1], entry_count[7:4],
	                                       // read_valid[8], read_score[40:9],
	                                       // read_tag[104:41], zero pad

	int fail_count;
	int pending;
	int refused_count;

	// idle/stall odds in percent, changed per phase
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	int submit_sent = 0;
	int read_sent   = 0;
	int hang_cycles = 0;

	always #5 clk = ~clk;

	top_k_sorted_insert_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	tkins_result_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.fail_count    (fail_count),
		.pending       (pending),
		.refused_count (refused_count)
	);

	// receiver backpressure, re-rolled every falling edge
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// hang watchdog: any transfer on either side resets the count
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			hang_cycles <= 0;
		else
			hang_cycles <= hang_cycles + 1;
		if (hang_cycles >= HANG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
				HANG_LIMIT, pending);
			$display("FAILURE");
			$finish;
		end
	end

	// One input transfer. Idle gaps are inserted before the item, never between
	// the acceptance of one item and the raise of the next in the same step, so
	// tvalid gets a single assignment per falling edge.
	task automatic send_rank_item(input action_t act, input logic signed [SCORE_W-1:0] score,
			input logic [TAG_W-1:0] tag, input logic [INDEX_W-1:0] idx);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {5'b0, idx, tag, score};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (act == ACT_SUBMIT)
			submit_sent++;
		else
			read_sent++;
	endtask

	// hold the sender off until every queued result has been seen
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// scores cluster in a narrow band so ties, refusals and evictions are common;
	// the rest are full-range or the extremes
	function automatic logic signed [SCORE_W-1:0] pick_score();
		int band;
		band = $urandom_range(16);
		case ($urandom_range(9))
			0:       return SCORE_MAX;
			1:       return SCORE_MIN;
			2, 3, 4: return $urandom;
			default: return band - 8;
		endcase
	endfunction

	task automatic run_random_phase(input int n_items, input int idle_pct, input int stall_pct);
		action_t act;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < n_items; i++) begin
			act = ($urandom_range(99) < 60) ? ACT_SUBMIT : ACT_READ;
			send_rank_item(act, pick_score(), {$urandom, $urandom},
				INDEX_W'($urandom_range(7)));
		end
		drain_results();
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// directed part, no idling
		// reads on the empty list: both ends of the index range, past the count
		send_rank_item(ACT_READ, '0, '0, 3'd0);
		send_rank_item(ACT_READ, '0, '0, 3'd7);
		// extremes of score and tag; each lands at its expected rank
		send_rank_item(ACT_SUBMIT, 32'sd0, '0, 3'd0);
		send_rank_item(ACT_SUBMIT, SCORE_MAX, TAG_ONES, 3'd7);
		send_rank_item(ACT_SUBMIT, SCORE_MIN, 64'h0123_4567_89ab_cdef, 3'd0);
		// equal score ranks behind the older zero
		send_rank_item(ACT_SUBMIT, 32'sd0, 64'h5a5a_5a5a_5a5a_5a5a, 3'd5);
		// fill the list up to its capacity
		send_rank_item(ACT_SUBMIT, 32'sd1, 64'h1111_1111_1111_1111, 3'd0);
		send_rank_item(ACT_SUBMIT, -32'sd1, 64'hffff_0000_ffff_0000, 3'd0);
		send_rank_item(ACT_SUBMIT, 32'sd5, 64'h5555_5555_5555_5555, 3'd0);
		send_rank_item(ACT_SUBMIT, 32'sd5, 64'haaaa_aaaa_aaaa_aaaa, 3'd0);
		// full list: equal to the lowest entry is refused
		send_rank_item(ACT_SUBMIT, SCORE_MIN, 64'hdead_0000_0000_0001, 3'd0);
		// full list: above the lowest evicts it
		send_rank_item(ACT_SUBMIT, -32'sd2, 64'h2222_2222_2222_2222, 3'd0);
		// full list: below every entry is refused
		send_rank_item(ACT_SUBMIT, SCORE_MIN, 64'hdead_0000_0000_0002, 3'd0);
		// tie with the top entry goes to rank one and pushes the tail off
		send_rank_item(ACT_SUBMIT, SCORE_MAX, 64'h7777_7777_7777_7777, 3'd0);
		// read back every rank
		for (int i = 0; i < 8; i++)
			send_rank_item(ACT_READ, '0, '0, i[INDEX_W-1:0]);

		// sender holds off until the pipeline is empty
		drain_results();

		// random phases with varying idle and stall odds
		run_random_phase(110, 0, 0);
		run_random_phase(110, 75, 0);
		run_random_phase(110, 0, 75);
		run_random_phase(120, 22, 22);

		// settle: wait until nothing is outstanding, then watch for a stray result
		recv_stall_pct = 0;
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d submits (%0d refused) and %0d reads across four idle/stall mixes",
			submit_sent, refused_count, read_sent);
		$display("%0d mismatches, %0d results outstanding", fail_count, pending);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/tkins_pkg.sv
rtl/tkins_cell.sv
rtl/top_k_sorted_insert_core.sv
verif/tkins_result_checker.sv
verif/tb_top_k_sorted_insert_core.sv
